// ----- rtl/core/fhd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fhd_pkg - frame header deframer shared definitions
// Header layout constants, result codes, parser phase and result word type.
// ----------------------------------------------------------------------------
package fhd_pkg;

  // header layout (byte offsets, little endian)
  localparam int HDR_BYTES = 16;
  localparam int OFS_TYPE  = 6;
  localparam int OFS_ID    = 8;
  localparam int OFS_LEN   = 12;
  localparam int POS_W     = $clog2(HDR_BYTES);

  // result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  localparam logic [1:0] CFG_MAGIC   = 2'd0;
  localparam logic [1:0] CFG_VERSION = 2'd1;
  localparam logic [1:0] CFG_MAX_LEN = 2'd2;

  // reset values of the configuration registers
  localparam logic [31:0] MAGIC_RST   = 32'd0;
  localparam logic [7:0]  VERSION_RST = 8'd1;
  localparam logic [31:0] MAX_LEN_RST = 32'd16777216;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DRAIN   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    K_HEADER = 2'd0,
    K_BYTE   = 2'd1,
    K_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    S_OK      = 3'd0,
    S_TRUNC   = 3'd1,
    S_MAGIC   = 3'd2,
    S_VERSION = 3'd3,
    S_LARGE   = 3'd4
  } status_t;

  typedef struct packed {
    kind_t        kind;
    status_t      status;
    logic [7:0]   frame_flags;
    logic [15:0]  frame_type;
    logic [31:0]  frame_tag;
    logic [31:0]  payload_length;
    logic [7:0]   payload_byte;
    logic         last_of_frame;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/core/frame_header_deframer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frame_header_deframer - magic/version/length frame parser
// Gathers a 16-byte little-endian header from a byte stream, checks it and
// forwards the payload bytes, reporting errors and truncation.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while the input is ready. Each accepted byte is
// parsed in the cycle it is taken (header byte gather, or one 32-bit length
// step and compare) and its results, if any and at most two, are written
// straight into a four-word result queue whose head drives out_. The input
// is ready whenever at least two queue slots are free, so with the output side
// ready the block sustains one byte per cycle; a buffer's final byte can
// raise both a result and a truncation word. Bytes after the payload or after
// a failed header are dropped, and the parser rearms after every byte
// flagged in_tlast. Configuration writes are taken at any time (cfg_ready is
// tied high) but should be made only while the block is idle.
// ----------------------------------------------------------------------------
module frame_header_deframer (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // byte input
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // [7:0] byte_in
  input  wire logic         in_tlast,   // end_of_buffer
  // results
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [2:0] status, [10:3] frame_flags, [26:11] frame_type,
  // [58:27] frame_tag, [90:59] payload_length, [98:91] payload_byte,
  // [103:99] zero
  output logic [103:0]      out_tdata,
  output logic [1:0]        out_tuser,  // [1:0] kind
  output logic              out_tlast,  // last_of_frame
  // configuration writes
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  localparam int PW = fhd_pkg::POS_W;

  // --- configuration -------------------------------------------------------
  logic [31:0] magic_r;
  logic [7:0]  version_r;
  logic [31:0] max_len_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= fhd_pkg::MAGIC_RST;
      version_r <= fhd_pkg::VERSION_RST;
      max_len_r <= fhd_pkg::MAX_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fhd_pkg::CFG_MAGIC:   magic_r   <= cfg_data;
        fhd_pkg::CFG_VERSION: version_r <= cfg_data[7:0];
        fhd_pkg::CFG_MAX_LEN: max_len_r <= cfg_data;
        default: ;  // unused index: ignored
      endcase
    end
  end

  // --- parser state --------------------------------------------------------
  fhd_pkg::phase_t phase_r, phase_nxt;
  logic [PW-1:0]   pos_r, pos_nxt;
  logic [31:0]     rem_r, rem_nxt;
  // header bytes 0..14; byte 15 is taken straight off the input
  logic [7:0]      hdr_r [0:fhd_pkg::HDR_BYTES-2];

  logic in_acc;
  logic out_acc;
  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  // assembled header fields, valid on the byte that completes the header
  logic [31:0] hdr_magic;
  logic [7:0]  hdr_version;
  logic [7:0]  hdr_flags;
  logic [15:0] hdr_type;
  logic [31:0] hdr_id;
  logic [31:0] hdr_len;
  logic [31:0] rem_dec;
  logic        hdr_last_byte;

  assign hdr_magic   = {hdr_r[3], hdr_r[2], hdr_r[1], hdr_r[0]};
  assign hdr_version = hdr_r[4];
  assign hdr_flags   = hdr_r[5];
  assign hdr_type    = {hdr_r[fhd_pkg::OFS_TYPE+1], hdr_r[fhd_pkg::OFS_TYPE]};
  assign hdr_id      = {hdr_r[fhd_pkg::OFS_ID+3], hdr_r[fhd_pkg::OFS_ID+2],
                        hdr_r[fhd_pkg::OFS_ID+1], hdr_r[fhd_pkg::OFS_ID]};
  assign hdr_len     = {in_tdata, hdr_r[fhd_pkg::OFS_LEN+2],
                        hdr_r[fhd_pkg::OFS_LEN+1], hdr_r[fhd_pkg::OFS_LEN]};
  assign rem_dec       = rem_r - 32'd1;
  assign hdr_last_byte = (pos_r == PW'(fhd_pkg::HDR_BYTES - 1));

  // results raised by the current byte
  fhd_pkg::result_t res0, res1, trunc_res;
  logic [1:0]       push_n;
  fhd_pkg::status_t hdr_status;

  always_comb begin
    trunc_res        = '0;
    trunc_res.kind   = fhd_pkg::K_ERROR;
    trunc_res.status = fhd_pkg::S_TRUNC;
    trunc_res.last_of_frame = 1'b1;

    // checks in order: magic, version, length cap
    if (hdr_magic != magic_r)        hdr_status = fhd_pkg::S_MAGIC;
    else if (hdr_version != version_r) hdr_status = fhd_pkg::S_VERSION;
    else if (hdr_len > max_len_r)    hdr_status = fhd_pkg::S_LARGE;
    else                             hdr_status = fhd_pkg::S_OK;

    res0      = '0;
    res1      = trunc_res;
    push_n    = 2'd0;
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    rem_nxt   = rem_r;

    case (phase_r)
      fhd_pkg::PH_HEADER: begin
        if (hdr_last_byte) begin
          pos_nxt = '0;
          push_n  = 2'd1;
          if (hdr_status != fhd_pkg::S_OK) begin
            res0.kind          = fhd_pkg::K_ERROR;
            res0.status        = hdr_status;
            res0.last_of_frame = 1'b1;
            phase_nxt          = fhd_pkg::PH_DRAIN;
          end else begin
            res0.kind           = fhd_pkg::K_HEADER;
            res0.status         = fhd_pkg::S_OK;
            res0.frame_flags    = hdr_flags;
            res0.frame_type     = hdr_type;
            res0.frame_tag      = hdr_id;
            res0.payload_length = hdr_len;
            res0.last_of_frame  = (hdr_len == 32'd0);
            if (hdr_len == 32'd0) begin
              phase_nxt = fhd_pkg::PH_DRAIN;
            end else begin
              phase_nxt = fhd_pkg::PH_PAYLOAD;
              rem_nxt   = hdr_len;
              if (in_tlast) push_n = 2'd2;  // header then truncation
            end
          end
        end else begin
          pos_nxt = pos_r + PW'(1);
          if (in_tlast) begin
            res0   = trunc_res;
            push_n = 2'd1;
          end
        end
      end
      fhd_pkg::PH_PAYLOAD: begin
        rem_nxt            = rem_dec;
        res0.kind          = fhd_pkg::K_BYTE;
        res0.status        = fhd_pkg::S_OK;
        res0.payload_byte  = in_tdata;
        res0.last_of_frame = (rem_dec == 32'd0);
        push_n             = 2'd1;
        if (rem_dec == 32'd0) phase_nxt = fhd_pkg::PH_DRAIN;
        else if (in_tlast)    push_n = 2'd2;
      end
      default: ;  // drain: byte dropped
    endcase

    // rearm on the buffer's final byte
    if (in_tlast) begin
      phase_nxt = fhd_pkg::PH_HEADER;
      pos_nxt   = '0;
      rem_nxt   = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= fhd_pkg::PH_HEADER;
      pos_r   <= '0;
      rem_r   <= 32'd0;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      rem_r   <= rem_nxt;
    end
  end

  // header byte capture; never cleared, every byte is rewritten before use
  always_ff @(posedge clk) begin
    for (int i = 0; i < fhd_pkg::HDR_BYTES - 1; i++) begin
      if (in_acc && phase_r == fhd_pkg::PH_HEADER && pos_r == PW'(i)) begin
        hdr_r[i] <= in_tdata;
      end
    end
  end

  // --- result queue ----------------------------------------------------------
  localparam int QW = fhd_pkg::QPTR_W;
  localparam int CW = fhd_pkg::QCNT_W;

  fhd_pkg::result_t q_r [0:fhd_pkg::QUEUE_DEPTH-1];
  logic [QW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [1:0]       push_acc;

  // room for the worst case of two words per byte
  assign in_tready = (cnt_r <= CW'(fhd_pkg::QUEUE_DEPTH - 2));
  assign push_acc  = in_acc ? push_n : 2'd0;
  assign cnt_nxt   = cnt_r + CW'(push_acc) - CW'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QW'(push_acc);
      rd_ptr_r <= rd_ptr_r + QW'(out_acc);
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_acc != 2'd0) q_r[wr_ptr_r]          <= res0;
    if (push_acc == 2'd2) q_r[wr_ptr_r + QW'(1)] <= res1;
  end

  fhd_pkg::result_t head;
  assign head       = q_r[rd_ptr_r];
  assign out_tvalid = (cnt_r != '0);
  assign out_tuser  = head.kind;
  assign out_tlast  = head.last_of_frame;
  assign out_tdata  = {5'd0, head.payload_byte, head.payload_length, head.frame_tag,
                       head.frame_type, head.frame_flags, head.status};

  // --- assertions ----------------------------------------------------------
  // queue never overfills
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(fhd_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  // a second word per byte only comes from a truncated buffer
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && push_n == 2'd2) |-> in_tlast)
    else $error("double result without end of buffer");

  // dropped bytes raise nothing
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && phase_r == fhd_pkg::PH_DRAIN) |-> (push_n == 2'd0))
    else $error("result raised while draining");

  // parser rearms after the final byte
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> (phase_r == fhd_pkg::PH_HEADER && pos_r == '0))
    else $error("parser not rearmed after end of buffer");

endmodule
`default_nettype wire
